// ===== rtl/heat_stencil_update_assert.svh =====
// Assertion macros shared by the heat stencil modules.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef HEAT_STENCIL_UPDATE_ASSERT_SVH
`define HEAT_STENCIL_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define HSU_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heat_stencil_update check failed");

// Next-cycle implication.
`define HSU_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heat_stencil_update check failed");

`endif

// ===== rtl/hsu_pkg.sv =====
package hsu_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int IDX_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int CNT_W    = 11;
   localparam int DATA_W   = 32;
   localparam int GAMMA_W  = 15;
   localparam int FRAC_W   = 16;
   localparam int LAP_W    = DATA_W + 3;
   localparam int PROD_W   = LAP_W + GAMMA_W + 1;
   localparam int DELTA_W  = PROD_W - FRAC_W;
   localparam int SUM_W    = DATA_W + 4;
   localparam int EXT_W    = LAP_W - DATA_W;
   localparam int TOP_W    = SUM_W - DATA_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd2;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 15'd6554;
   localparam logic [GAMMA_W-1:0] GAMMA_LIMIT = 15'd16384;
   localparam logic [CNT_W-1:0]   COLS_RESET  = 11'd1024;
   localparam logic [CNT_W-1:0]   ROWS_RESET  = 11'd1024;
   localparam logic [CNT_W-1:0]   MIN_DIM     = 11'd3;
   localparam logic [CNT_W-1:0]   COLS_LIMIT  = CNT_W'(MAX_COLS);
   localparam logic [CNT_W-1:0]   ROWS_LIMIT  = CNT_W'(MAX_ROWS);

   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);
   localparam logic [DATA_W-1:0] SAT_MAX    = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN    = 32'h8000_0000;

   typedef struct packed {
      logic stencil_v;
      logic pass_v;
      logic edge_pt;
      logic last_pt;
   } hsu_tag_type;

   typedef struct packed {
      hsu_tag_type      tag;
      logic             col_first;
      logic             bank;
      logic [IDX_W-1:0] col;
   } hsu_item_type;

endpackage

// ===== rtl/hsu_row_bank.sv =====
module hsu_row_bank (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [hsu_pkg::IDX_W-1:0]  rd_addr,
   input  logic                       wr_en,
   input  logic [hsu_pkg::IDX_W-1:0]  wr_addr,
   input  logic [hsu_pkg::DATA_W-1:0] wr_data,
   output logic [hsu_pkg::DATA_W-1:0] rd_data
);

   logic [hsu_pkg::DATA_W-1:0] row_mem [hsu_pkg::MAX_COLS];
   logic [hsu_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hsu_addr_gen.sv =====
`include "heat_stencil_update_assert.svh"

module hsu_addr_gen (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [hsu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hsu_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           accept,
   output hsu_pkg::hsu_item_type          item,
   output logic [hsu_pkg::GAMMA_W-1:0]    gamma_use
);

   logic [hsu_pkg::GAMMA_W-1:0] gamma_ff, gamma_in;
   logic [hsu_pkg::CNT_W-1:0]   col_count_ff, col_count_in;
   logic [hsu_pkg::CNT_W-1:0]   row_count_ff, row_count_in;
   logic [hsu_pkg::IDX_W-1:0]   col_index_ff, col_index_in;
   logic [hsu_pkg::ROW_W-1:0]   row_index_ff, row_index_in;

   logic [hsu_pkg::CNT_W-1:0] cols_used;
   logic [hsu_pkg::CNT_W-1:0] rows_used;
   logic [hsu_pkg::CNT_W-1:0] col_ext;
   logic [hsu_pkg::CNT_W-1:0] row_ext;
   logic                      last_col;
   logic                      last_row;

   always_comb begin
      if (col_count_ff < hsu_pkg::MIN_DIM) begin
         cols_used = hsu_pkg::MIN_DIM;
      end else if (col_count_ff > hsu_pkg::COLS_LIMIT) begin
         cols_used = hsu_pkg::COLS_LIMIT;
      end else begin
         cols_used = col_count_ff;
      end
      if (row_count_ff < hsu_pkg::MIN_DIM) begin
         rows_used = hsu_pkg::MIN_DIM;
      end else if (row_count_ff > hsu_pkg::ROWS_LIMIT) begin
         rows_used = hsu_pkg::ROWS_LIMIT;
      end else begin
         rows_used = row_count_ff;
      end
   end

   assign col_ext  = {{(hsu_pkg::CNT_W-hsu_pkg::IDX_W){1'b0}}, col_index_ff};
   assign row_ext  = {{(hsu_pkg::CNT_W-hsu_pkg::ROW_W){1'b0}}, row_index_ff};
   assign last_col = (col_ext == cols_used - hsu_pkg::CNT_W'(1));
   assign last_row = (row_ext == rows_used - hsu_pkg::CNT_W'(1));

   assign gamma_use = (gamma_ff > hsu_pkg::GAMMA_LIMIT) ? hsu_pkg::GAMMA_LIMIT : gamma_ff;

   always_comb begin
      item.tag.stencil_v = (row_index_ff != '0);
      item.tag.pass_v    = last_row;
      item.tag.edge_pt   = (row_index_ff == hsu_pkg::ROW_W'(1)) || (col_index_ff == '0)
                           || last_col;
      item.tag.last_pt   = last_row && last_col;
      item.col_first     = (col_index_ff == '0);
      item.bank          = row_index_ff[0];
      item.col           = col_index_ff;
   end

   always_comb begin
      gamma_in     = gamma_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      col_index_in = col_index_ff;
      row_index_in = row_index_ff;
      if (csr_wr_en) begin
         case (csr_index)
            hsu_pkg::CSR_GAMMA: begin
               gamma_in = csr_wdata[hsu_pkg::GAMMA_W-1:0];
            end
            hsu_pkg::CSR_COLS: begin
               col_count_in = csr_wdata[hsu_pkg::CNT_W-1:0];
               col_index_in = '0;
               row_index_in = '0;
            end
            hsu_pkg::CSR_ROWS: begin
               row_count_in = csr_wdata[hsu_pkg::CNT_W-1:0];
               col_index_in = '0;
               row_index_in = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (last_row && last_col) begin
            col_index_in = '0;
            row_index_in = '0;
         end else if (last_col) begin
            col_index_in = '0;
            row_index_in = row_index_ff + hsu_pkg::ROW_W'(1);
         end else begin
            col_index_in = col_index_ff + hsu_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff     <= hsu_pkg::GAMMA_RESET;
         col_count_ff <= hsu_pkg::COLS_RESET;
         row_count_ff <= hsu_pkg::ROWS_RESET;
         col_index_ff <= '0;
         row_index_ff <= '0;
      end else begin
         gamma_ff     <= gamma_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         col_index_ff <= col_index_in;
         row_index_ff <= row_index_in;
      end
   end

   `HSU_CHECK(col_in_range, 1'b1, col_ext < cols_used)
   `HSU_CHECK(row_in_range, 1'b1, row_ext < rows_used)

endmodule

// ===== rtl/hsu_stencil_pipe.sv =====
`include "heat_stencil_update_assert.svh"

module hsu_stencil_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  hsu_pkg::hsu_item_type       item,
   input  logic [hsu_pkg::DATA_W-1:0]  sample,
   input  logic [hsu_pkg::DATA_W-1:0]  rd0,
   input  logic [hsu_pkg::DATA_W-1:0]  rd1,
   input  logic [hsu_pkg::GAMMA_W-1:0] gamma_use,
   input  logic                        rsp_stall,
   output logic                        advance,
   output logic                        rsp_valid,
   output logic [hsu_pkg::DATA_W-1:0]  rsp_sample_out,
   output logic                        rsp_frame_end
);

   // stage 1: window around the current column
   logic                       s1_v_ff;
   hsu_pkg::hsu_tag_type       s1_tag_ff;
   logic [hsu_pkg::DATA_W-1:0] s1_sample_ff;
   logic                       sel_ff;
   logic [hsu_pkg::DATA_W-1:0] center_ff;
   logic [hsu_pkg::DATA_W-1:0] west_ff;
   logic [hsu_pkg::DATA_W-1:0] col0_ff;

   logic                       s2_v_ff;
   hsu_pkg::hsu_tag_type       s2_tag_ff;
   logic [hsu_pkg::DATA_W-1:0] s2_sample_ff;
   logic [hsu_pkg::DATA_W-1:0] s2_center_ff;
   logic [hsu_pkg::LAP_W-1:0]  s2_lap_ff;

   logic                              s3_v_ff;
   hsu_pkg::hsu_tag_type              s3_tag_ff;
   logic [hsu_pkg::DATA_W-1:0]        s3_sample_ff;
   logic [hsu_pkg::DATA_W-1:0]        s3_center_ff;
   logic signed [hsu_pkg::PROD_W-1:0] s3_prod_ff;

   logic                        s4_v_ff;
   hsu_pkg::hsu_tag_type        s4_tag_ff;
   logic [hsu_pkg::DATA_W-1:0]  s4_sample_ff;
   logic [hsu_pkg::DATA_W-1:0]  s4_center_ff;
   logic [hsu_pkg::DELTA_W-1:0] s4_delta_ff;

   logic                       a_v_ff;
   logic [hsu_pkg::DATA_W-1:0] a_data_ff;
   logic                       b_v_ff;
   logic [hsu_pkg::DATA_W-1:0] b_data_ff;
   logic                       b_fe_ff;

   logic [hsu_pkg::DATA_W-1:0]        north;
   logic [hsu_pkg::DATA_W-1:0]        east;
   logic [hsu_pkg::LAP_W-1:0]         lap;
   logic signed [hsu_pkg::PROD_W-1:0] prod;
   logic [hsu_pkg::PROD_W-1:0]        rounded;
   logic [hsu_pkg::SUM_W-1:0]         sum;
   logic [hsu_pkg::TOP_W-1:0]         sum_top;
   logic [hsu_pkg::DATA_W-1:0]        stencil_val;
   logic [hsu_pkg::DATA_W-1:0]        a_data_in;
   logic                              pop;

   assign north = sel_ff ? rd1 : rd0;
   assign east  = sel_ff ? rd0 : rd1;

   assign lap = {{hsu_pkg::EXT_W{north[hsu_pkg::DATA_W-1]}}, north}
              + {{hsu_pkg::EXT_W{s1_sample_ff[hsu_pkg::DATA_W-1]}}, s1_sample_ff}
              + {{hsu_pkg::EXT_W{east[hsu_pkg::DATA_W-1]}}, east}
              + {{hsu_pkg::EXT_W{west_ff[hsu_pkg::DATA_W-1]}}, west_ff}
              - {center_ff[hsu_pkg::DATA_W-1], center_ff, 2'b00};

   assign prod    = $signed(s2_lap_ff) * $signed({1'b0, gamma_use});
   assign rounded = s3_prod_ff + hsu_pkg::ROUND_BIAS;

   assign sum = {{(hsu_pkg::SUM_W-hsu_pkg::DATA_W){s4_center_ff[hsu_pkg::DATA_W-1]}},
                 s4_center_ff}
              + {{(hsu_pkg::SUM_W-hsu_pkg::DELTA_W){s4_delta_ff[hsu_pkg::DELTA_W-1]}},
                 s4_delta_ff};
   assign sum_top = sum[hsu_pkg::SUM_W-1:hsu_pkg::DATA_W-1];

   always_comb begin
      if ((sum_top == '0) || (sum_top == '1)) begin
         stencil_val = sum[hsu_pkg::DATA_W-1:0];
      end else if (sum[hsu_pkg::SUM_W-1]) begin
         stencil_val = hsu_pkg::SAT_MIN;
      end else begin
         stencil_val = hsu_pkg::SAT_MAX;
      end
      a_data_in = s4_tag_ff.edge_pt ? s4_center_ff : stencil_val;
   end

   assign rsp_valid      = a_v_ff || b_v_ff;
   assign rsp_sample_out = a_v_ff ? a_data_ff : b_data_ff;
   assign rsp_frame_end  = !a_v_ff && b_fe_ff;
   assign pop            = rsp_valid && !rsp_stall;
   assign advance        = !(a_v_ff || b_v_ff) || (pop && !(a_v_ff && b_v_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         a_v_ff  <= s4_v_ff && s4_tag_ff.stencil_v;
         b_v_ff  <= s4_v_ff && s4_tag_ff.pass_v;
      end else if (pop) begin
         if (a_v_ff) begin
            a_v_ff <= 1'b0;
         end else begin
            b_v_ff <= 1'b0;
         end
      end
   end

   // slide the previous-row window on every accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff    <= item.tag;
         s1_sample_ff <= sample;
         sel_ff       <= item.bank;
         west_ff      <= center_ff;
         center_ff    <= item.col_first ? col0_ff : east;
         if (item.col_first) begin
            col0_ff <= sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_tag_ff    <= s1_tag_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_center_ff <= center_ff;
         s2_lap_ff    <= lap;
         s3_tag_ff    <= s2_tag_ff;
         s3_sample_ff <= s2_sample_ff;
         s3_center_ff <= s2_center_ff;
         s3_prod_ff   <= prod;
         s4_tag_ff    <= s3_tag_ff;
         s4_sample_ff <= s3_sample_ff;
         s4_center_ff <= s3_center_ff;
         s4_delta_ff  <= rounded[hsu_pkg::PROD_W-1:hsu_pkg::FRAC_W];
         a_data_ff    <= a_data_in;
         b_data_ff    <= s4_sample_ff;
         b_fe_ff      <= s4_tag_ff.last_pt;
      end
   end

   `HSU_CHECK(frame_end_second, a_v_ff, !rsp_frame_end)
   `HSU_CHECK_NEXT(pair_holds, a_v_ff && b_v_ff && rsp_stall, a_v_ff && b_v_ff)

endmodule

// ===== rtl/heat_stencil_update.sv =====
// One explicit time step of the 2D heat equation over a streamed grid.
// Input channel (req_*): old grid samples in row-major order, one per
// transaction, signed Q16.16. Result channel (rsp_*): new grid samples in
// the same order, saturated; rsp_frame_end marks the last point of a grid.
// Configuration (csr_*): gamma_coeff, col_count and row_count; writing a
// size restarts the frame at row 0, column 0.
// The first row produces no result. Each later input produces the point one
// row above it, through stages s1 to s4 and the output register; during the
// last row each input also returns itself, so the final row is flushed with
// the last input. Throughput is one transaction per cycle while rsp_stall is
// low, set by the single read and write port of each of the two row banks;
// a last-row input yields two results, and the next waits till the first leaves.
// Reset clears the position counters, the pipeline and the sizes to 1024 by
// 1024 with gamma 6554; the row banks are not cleared and need no sweep.
// When rsp_stall is high with a result waiting, the result holds and the
// pipeline freezes, which raises req_stall in the same cycle; a pair of
// results in the last row also raises req_stall until the first one leaves.
module heat_stencil_update (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hsu_pkg::DATA_W-1:0]     req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hsu_pkg::DATA_W-1:0]     rsp_sample_out,
   output logic                           rsp_frame_end,
   input  logic                           csr_wr_en,
   input  logic [hsu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hsu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   hsu_pkg::hsu_item_type       item;
   logic [hsu_pkg::GAMMA_W-1:0] gamma_use;
   logic                        advance;
   logic                        accept;
   logic [hsu_pkg::IDX_W-1:0]   col_next;
   logic [hsu_pkg::IDX_W-1:0]   rd_addr0;
   logic [hsu_pkg::IDX_W-1:0]   rd_addr1;
   logic                        wr_en0;
   logic                        wr_en1;
   logic [hsu_pkg::DATA_W-1:0]  rd0;
   logic [hsu_pkg::DATA_W-1:0]  rd1;

   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // current row bank reads north at this column, the other bank reads ahead by one
   assign col_next = item.col + hsu_pkg::IDX_W'(1);
   assign rd_addr0 = item.bank ? col_next : item.col;
   assign rd_addr1 = item.bank ? item.col : col_next;
   assign wr_en0   = accept && !item.bank;
   assign wr_en1   = accept && item.bank;

   hsu_addr_gen u_addr_gen (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .item      (item),
      .gamma_use (gamma_use)
   );

   hsu_row_bank u_bank0 (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr0),
      .wr_en   (wr_en0),
      .wr_addr (item.col),
      .wr_data (req_sample_in),
      .rd_data (rd0)
   );

   hsu_row_bank u_bank1 (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr1),
      .wr_en   (wr_en1),
      .wr_addr (item.col),
      .wr_data (req_sample_in),
      .rd_data (rd1)
   );

   hsu_stencil_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .item           (item),
      .sample         (req_sample_in),
      .rd0            (rd0),
      .rd1            (rd1),
      .gamma_use      (gamma_use),
      .rsp_stall      (rsp_stall),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [hsu_pkg::DATA_W-1:0] sample_out;
      logic                       frame_end;
   } grid_point_type;

   localparam logic [hsu_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 12;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [hsu_pkg::DATA_W-1:0]     req_sample_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [hsu_pkg::DATA_W-1:0]     rsp_sample_out;
   logic                           rsp_frame_end;
   logic                           csr_wr_en = 1'b0;
   logic [hsu_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [hsu_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [hsu_pkg::DATA_W-1:0] pending_samples[$];
   grid_point_type             expected_points[$];
   int                         fail_count = 0;

   logic [hsu_pkg::DATA_W-1:0]  grid_rows [2*hsu_pkg::MAX_COLS];
   logic [hsu_pkg::GAMMA_W-1:0] gamma_reg = hsu_pkg::GAMMA_RESET;
   logic [hsu_pkg::CNT_W-1:0]   cols_reg = hsu_pkg::COLS_RESET;
   logic [hsu_pkg::CNT_W-1:0]   rows_reg = hsu_pkg::ROWS_RESET;
   int unsigned                 at_row = 0;
   int unsigned                 at_col = 0;

   int send_gap = 0;
   int recv_wait = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;

   logic [hsu_pkg::DATA_W-1:0] corner_values [12] = '{
      hsu_pkg::SAT_MAX, hsu_pkg::SAT_MIN, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h0000_0001, hsu_pkg::SAT_MAX,
      hsu_pkg::SAT_MAX, hsu_pkg::SAT_MAX, hsu_pkg::SAT_MIN,
      32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000
   };
   logic [hsu_pkg::DATA_W-1:0] tail_values [6] = '{
      32'h0000_0001, 32'h4000_0000, 32'hC000_0000,
      32'h0000_0003, 32'hFFFF_FFFD, 32'h0002_0000
   };

   heat_stencil_update uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_frame_end  (rsp_frame_end),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int unsigned dim_used(logic [hsu_pkg::CNT_W-1:0] val,
                                            logic [hsu_pkg::CNT_W-1:0] limit);
      if (val < hsu_pkg::MIN_DIM) return 32'(hsu_pkg::MIN_DIM);
      if (val > limit) return 32'(limit);
      return 32'(val);
   endfunction

   function automatic logic [hsu_pkg::DATA_W-1:0] diffuse(
         logic signed [hsu_pkg::DATA_W-1:0] north,
         logic signed [hsu_pkg::DATA_W-1:0] south,
         logic signed [hsu_pkg::DATA_W-1:0] east,
         logic signed [hsu_pkg::DATA_W-1:0] west,
         logic signed [hsu_pkg::DATA_W-1:0] center);
      logic [hsu_pkg::GAMMA_W-1:0] g;
      longint                      lap;
      longint                      delta;
      longint                      total;
      g = (gamma_reg > hsu_pkg::GAMMA_LIMIT) ? hsu_pkg::GAMMA_LIMIT : gamma_reg;
      lap = longint'(north) + longint'(south) + longint'(east) + longint'(west)
            - 4 * longint'(center);
      // round half up, then floor via arithmetic shift
      delta = (lap * longint'(g) + 64'sd32768) >>> 16;
      total = longint'(center) + delta;
      if (total > 64'sd2147483647) return hsu_pkg::SAT_MAX;
      if (total < -64'sd2147483648) return hsu_pkg::SAT_MIN;
      return total[hsu_pkg::DATA_W-1:0];
   endfunction

   task automatic advance_grid(input logic [hsu_pkg::DATA_W-1:0] sample);
      int unsigned                cols;
      int unsigned                rows;
      int unsigned                r;
      int unsigned                c;
      int unsigned                cur;
      int unsigned                prv;
      logic                       last_row;
      logic                       last_pt;
      logic [hsu_pkg::DATA_W-1:0] value;
      cols = dim_used(cols_reg, hsu_pkg::COLS_LIMIT);
      rows = dim_used(rows_reg, hsu_pkg::ROWS_LIMIT);
      if (at_col >= cols || at_row >= rows) begin
         at_col = 0;
         at_row = 0;
      end
      r = at_row;
      c = at_col;
      cur = (r % 2) * hsu_pkg::MAX_COLS;
      prv = ((r + 1) % 2) * hsu_pkg::MAX_COLS;
      last_row = (r == rows - 1);
      last_pt = last_row && (c == cols - 1);
      if (r >= 1) begin
         if (r == 1 || c == 0 || c == cols - 1) begin
            value = grid_rows[prv + c];
         end else begin
            value = diffuse(grid_rows[cur + c], sample, grid_rows[prv + c + 1],
                            grid_rows[prv + c - 1], grid_rows[prv + c]);
         end
         expected_points.push_back('{sample_out: value, frame_end: 1'b0});
      end
      grid_rows[cur + c] = sample;
      if (last_row) begin
         expected_points.push_back('{sample_out: sample, frame_end: last_pt});
      end
      if (last_pt) begin
         at_row = 0;
         at_col = 0;
      end else if (c == cols - 1) begin
         at_col = 0;
         at_row = r + 1;
      end else begin
         at_col = c + 1;
      end
   endtask

   function automatic logic [hsu_pkg::DATA_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return hsu_pkg::SAT_MAX;
               1: return hsu_pkg::SAT_MIN;
               2: return '0;
               3: return hsu_pkg::SAT_MAX - hsu_pkg::DATA_W'($urandom_range(0, 255));
               default: return '1;
            endcase
         end
         1, 2: return hsu_pkg::DATA_W'($urandom());
         default: return hsu_pkg::DATA_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   function automatic logic [hsu_pkg::CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return hsu_pkg::CSR_DATA_W'($urandom_range(0, 2));
         1: return hsu_pkg::CSR_DATA_W'($urandom_range(11, 24));
         2: return hsu_pkg::CSR_DATA_W'($urandom());
         default: return hsu_pkg::CSR_DATA_W'($urandom_range(3, 8));
      endcase
   endfunction

   task automatic write_csr(input logic [hsu_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hsu_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         hsu_pkg::CSR_GAMMA: gamma_reg = data;
         hsu_pkg::CSR_COLS: begin
            cols_reg = data[hsu_pkg::CNT_W-1:0];
            at_row = 0;
            at_col = 0;
         end
         hsu_pkg::CSR_ROWS: begin
            rows_reg = data[hsu_pkg::CNT_W-1:0];
            at_row = 0;
            at_col = 0;
         end
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic feed_random(input int unsigned n);
      @(negedge clock);
      repeat (n) pending_samples.push_back(draw_sample());
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      logic fire;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) advance_grid(req_sample_in);
         if (fire || !req_valid) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_samples.size() > 0) begin
               req_sample_in <= pending_samples.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
               send_gap = send_calm ? 0 : int'($urandom_range(0, 3));
            end
            req_valid <= next_valid;
         end
      end
   end

   always @(posedge clock) begin
      grid_point_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("unexpected transaction: sample_out %h frame_end %b",
                      rsp_sample_out, rsp_frame_end);
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_sample_out !== want.sample_out) begin
                  $error("sample_out mismatch: expected %h, actual %h",
                         want.sample_out, rsp_sample_out);
                  fail_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end mismatch: expected %b, actual %b",
                         want.frame_end, rsp_frame_end);
                  fail_count++;
               end
            end
            if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
            recv_wait = recv_calm ? 0 : int'($urandom_range(0, 3));
         end
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int unsigned taken;
      int unsigned count;
      @(negedge clock);
      while (reset) @(negedge clock);

      // reset sizes: part of row 0, no results, then restart
      feed_random(12);
      wait_idle();
      write_csr(hsu_pkg::CSR_ROWS, hsu_pkg::CSR_DATA_W'(3));
      feed_random(20);
      wait_idle();

      write_csr(hsu_pkg::CSR_COLS, hsu_pkg::CSR_DATA_W'(3));
      write_csr(hsu_pkg::CSR_GAMMA, hsu_pkg::CSR_DATA_W'(hsu_pkg::GAMMA_LIMIT));
      @(negedge clock);
      foreach (corner_values[i]) pending_samples.push_back(corner_values[i]);
      wait_idle();
      // gamma changes mid-frame without restart
      write_csr(hsu_pkg::CSR_GAMMA, '0);
      write_csr(CSR_UNUSED, hsu_pkg::CSR_DATA_W'($urandom()));
      @(negedge clock);
      for (int i = 0; i < 3; i++) pending_samples.push_back(tail_values[i]);
      wait_idle();
      write_csr(hsu_pkg::CSR_GAMMA, '1);
      @(negedge clock);
      for (int i = 3; i < 6; i++) pending_samples.push_back(tail_values[i]);
      wait_idle();

      write_csr(hsu_pkg::CSR_COLS, '0);
      write_csr(hsu_pkg::CSR_ROWS, '1);
      write_csr(hsu_pkg::CSR_GAMMA, hsu_pkg::CSR_DATA_W'($urandom_range(0, 16384)));
      feed_random(60);
      wait_idle();

      taken = 0;
      while (taken < 690) begin
         if ($urandom_range(0, 2) != 0) begin
            write_csr(hsu_pkg::CSR_COLS, pick_dim());
            write_csr(hsu_pkg::CSR_ROWS, pick_dim());
         end
         if ($urandom_range(0, 3) == 0) begin
            write_csr(hsu_pkg::CSR_GAMMA, hsu_pkg::CSR_DATA_W'($urandom()));
         end else begin
            write_csr(hsu_pkg::CSR_GAMMA, hsu_pkg::CSR_DATA_W'($urandom_range(0, 16384)));
         end
         if ($urandom_range(0, 9) == 0) begin
            write_csr(CSR_UNUSED, hsu_pkg::CSR_DATA_W'($urandom()));
         end
         count = dim_used(cols_reg, hsu_pkg::COLS_LIMIT)
                 * dim_used(rows_reg, hsu_pkg::ROWS_LIMIT) * $urandom_range(1, 2);
         if (count > 120 || $urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, (count > 120) ? 120 : count);
         end
         feed_random(count);
         taken += count;
         wait_idle();
      end

      if (fail_count == 0 && expected_points.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
